@@ src/mfns_pkg.sv @@
// ----------------------------------------------------------------------------
// mfns_pkg
// Shared types and constants for the median filtered nearest sensor block.
// ----------------------------------------------------------------------------
package mfns_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 10;
	localparam int CH_W     = 4;
	localparam int DEG_W    = 9;

	// median reported for a channel with no samples
	localparam logic [SAMPLE_W-1:0] EMPTY_MEDIAN = 10'd1023;

	// degrees per channel step
	localparam logic [DEG_W-1:0] DEG_STEP = 9'd30;

	// item modes
	localparam logic MODE_ADD   = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// query sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CH_START,
		ST_CAND,
		ST_CAND_WAIT,
		ST_SCAN,
		ST_SCAN_TAIL,
		ST_CAND_END,
		ST_MED,
		ST_CH_END,
		ST_DONE
	} seq_state_t;

	// control from sequencer to the rank unit
	typedef struct packed {
		logic load_cand;
		logic acc;
		logic eval;
	} rank_ctl_t;

endpackage

@@ src/mfns_store.sv @@
// ----------------------------------------------------------------------------
// mfns_store
// Sample window memory: one write port, one registered read port.
// ----------------------------------------------------------------------------
module mfns_store
	import mfns_pkg::*;
#(
	parameter int DEPTH = 108,
	parameter int AW    = 7
) (
	input  logic                clk,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  logic [SAMPLE_W-1:0] wr_data,
	input  logic [AW-1:0]       rd_addr,
	output logic [SAMPLE_W-1:0] rd_data
);

	logic [SAMPLE_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

@@ src/mfns_rank.sv @@
// ----------------------------------------------------------------------------
// mfns_rank
// Shared compare unit: ranks one candidate sample against a channel window
// and captures the values at the two middle ranks.
// ----------------------------------------------------------------------------
module mfns_rank
	import mfns_pkg::*;
#(
	parameter int CW = 4
) (
	input  logic                clk,
	input  rank_ctl_t           ctl,
	input  logic [SAMPLE_W-1:0] rd_data,
	input  logic [CW-1:0]       k_lo,
	input  logic [CW-1:0]       k_hi,
	output logic [SAMPLE_W-1:0] lo_val,
	output logic [SAMPLE_W-1:0] hi_val
);

	logic [SAMPLE_W-1:0] cand_q;
	logic [CW-1:0]       lt_q;
	logic [CW-1:0]       le_q;
	logic [SAMPLE_W-1:0] lo_q;
	logic [SAMPLE_W-1:0] hi_q;

	// candidate load and rank counting
	always_ff @(posedge clk) begin
		if (ctl.load_cand) begin
			cand_q <= rd_data;
			lt_q   <= '0;
			le_q   <= '0;
		end else if (ctl.acc) begin
			lt_q <= lt_q + CW'(rd_data < cand_q);
			le_q <= le_q + CW'(rd_data <= cand_q);
		end
	end

	// candidate sits at rank k when lt <= k < le
	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			if (lt_q <= k_lo && k_lo < le_q) begin
				lo_q <= cand_q;
			end
			if (lt_q <= k_hi && k_hi < le_q) begin
				hi_q <= cand_q;
			end
		end
	end

	assign lo_val = lo_q;
	assign hi_val = hi_q;

endmodule

@@ src/mfns_seq.sv @@
// ----------------------------------------------------------------------------
// mfns_seq
// Sequencer: stores samples into the ring windows and walks every channel
// on a query, driving the rank unit and tracking the lowest median.
// ----------------------------------------------------------------------------
module mfns_seq
	import mfns_pkg::*;
#(
	parameter int WINDOW   = 9,
	parameter int CHANNELS = 12,
	parameter int AW       = 7,
	parameter int CW       = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic                mode,
	input  logic [CH_W-1:0]     channel,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                wr_en,
	output logic [AW-1:0]       wr_addr,
	output logic [SAMPLE_W-1:0] wr_data,
	output logic [AW-1:0]       rd_addr,
	output rank_ctl_t           rank_ctl,
	output logic [CW-1:0]       k_lo,
	output logic [CW-1:0]       k_hi,
	input  logic [SAMPLE_W-1:0] lo_val,
	input  logic [SAMPLE_W-1:0] hi_val,
	output logic                result_rdy,
	input  logic                result_take,
	output logic [CH_W-1:0]     best_ch,
	output logic [SAMPLE_W-1:0] best_med
);

	localparam int ChIdxW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	seq_state_t state_q, state_d;

	logic [CW-1:0]       fill_q [CHANNELS];
	logic [CW-1:0]       slot_q [CHANNELS];
	logic [ChIdxW-1:0]   tbl_idx;
	logic [CW-1:0]       fill_rd;
	logic [CW-1:0]       slot_rd;
	logic                ch_in_range;
	logic                add_en;

	logic [ChIdxW-1:0]   ch_q;
	logic [CW-1:0]       n_q;
	logic [CW-1:0]       i_q;
	logic [CW-1:0]       j_q;
	logic [AW-1:0]       base_q;
	logic [SAMPLE_W-1:0] med_q;
	logic [SAMPLE_W-1:0] best_med_q;
	logic [ChIdxW-1:0]   best_ch_q;
	logic                pend_s1;

	// per-channel table lookup, one address at a time
	assign tbl_idx     = (state_q == ST_IDLE) ? channel[ChIdxW-1:0] : ch_q;
	assign fill_rd     = fill_q[tbl_idx];
	assign slot_rd     = slot_q[tbl_idx];
	assign ch_in_range = ({1'b0, channel} < (CH_W + 1)'(CHANNELS));
	assign req_ready   = (state_q == ST_IDLE);
	assign add_en      = req_valid && req_ready && (mode == MODE_ADD) && ch_in_range;

	// sample write into the ring slot
	assign wr_en   = add_en;
	assign wr_addr = AW'(channel[ChIdxW-1:0]) * AW'(WINDOW) + AW'(slot_rd);
	assign wr_data = sample;

	// fill counts and next slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				fill_q[c] <= '0;
				slot_q[c] <= '0;
			end
		end else if (add_en) begin
			slot_q[tbl_idx] <= (slot_rd == CW'(WINDOW - 1)) ? '0 : slot_rd + 1'b1;
			if (fill_rd < CW'(WINDOW)) begin
				fill_q[tbl_idx] <= fill_rd + 1'b1;
			end
		end
	end

	// middle ranks of the current channel
	assign k_lo = (n_q - 1'b1) >> 1;
	assign k_hi = n_q >> 1;

	// memory read address: candidate or scanned entry
	assign rd_addr = base_q + AW'((state_q == ST_CAND) ? i_q : j_q);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pend_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_s1 <= (state_q == ST_SCAN);
		end
	end

	// next state and control
	always_comb begin
		state_d            = state_q;
		rank_ctl.load_cand = (state_q == ST_CAND_WAIT);
		rank_ctl.acc       = pend_s1;
		rank_ctl.eval      = (state_q == ST_CAND_END);
		result_rdy         = (state_q == ST_DONE);
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid && mode == MODE_QUERY) begin
					state_d = ST_CH_START;
				end
			end
			ST_CH_START: begin
				state_d = (fill_rd == '0) ? ST_CH_END : ST_CAND;
			end
			ST_CAND:      state_d = ST_CAND_WAIT;
			ST_CAND_WAIT: state_d = ST_SCAN;
			ST_SCAN: begin
				if (j_q == n_q - 1'b1) begin
					state_d = ST_SCAN_TAIL;
				end
			end
			ST_SCAN_TAIL: state_d = ST_CAND_END;
			ST_CAND_END: begin
				state_d = (i_q == n_q - 1'b1) ? ST_MED : ST_CAND;
			end
			ST_MED:       state_d = ST_CH_END;
			ST_CH_END: begin
				state_d = (ch_q == ChIdxW'(CHANNELS - 1)) ? ST_DONE : ST_CH_START;
			end
			ST_DONE: begin
				if (result_take) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// query datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ch_q <= '0;
			end
			ST_CH_START: begin
				n_q    <= fill_rd;
				base_q <= AW'(ch_q) * AW'(WINDOW);
				i_q    <= '0;
				med_q  <= EMPTY_MEDIAN;
			end
			ST_CAND_WAIT: begin
				j_q <= '0;
			end
			ST_SCAN: begin
				j_q <= j_q + 1'b1;
			end
			ST_CAND_END: begin
				i_q <= i_q + 1'b1;
			end
			ST_MED: begin
				med_q <= SAMPLE_W'(({1'b0, lo_val} + {1'b0, hi_val}) >> 1);
			end
			ST_CH_END: begin
				if (ch_q == '0 || med_q < best_med_q) begin
					best_med_q <= med_q;
					best_ch_q  <= ch_q;
				end
				ch_q <= ch_q + 1'b1;
			end
			ST_CAND, ST_SCAN_TAIL, ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	assign best_ch  = CH_W'(best_ch_q);
	assign best_med = best_med_q;

endmodule

@@ src/median_filtered_nearest_sensor.sv @@
// ----------------------------------------------------------------------------
// median_filtered_nearest_sensor
// Keeps a sliding sample window per sensor channel and, on a query, returns
// the channel with the lowest running median and its direction in degrees.
//
//   channel  handshake             fields
//   req      req_valid/req_ready   mode, channel, sample
//   res      res_valid/res_ready   nearest_channel, direction_deg, nearest_median
//
// A sample item is stored and gives no result.
// A query ranks every candidate against its window on the single compare unit.
// req_ready is low while a query runs and until its result enters the
// output register; the result waits there for res_ready.
// Reset clears fill counts and ring pointers; the sample memory is not cleared.
// ----------------------------------------------------------------------------
module median_filtered_nearest_sensor
	import mfns_pkg::*;
#(
	parameter int WINDOW   = 9,
	parameter int CHANNELS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic                mode,
	input  logic [CH_W-1:0]     channel,
	input  logic [SAMPLE_W-1:0] sample,
	output logic                res_valid,
	input  logic                res_ready,
	output logic [CH_W-1:0]     nearest_channel,
	output logic [DEG_W-1:0]    direction_deg,
	output logic [SAMPLE_W-1:0] nearest_median
);

	localparam int Depth = CHANNELS * WINDOW;
	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(WINDOW + 1);

	logic                wr_en;
	logic [AddrW-1:0]    wr_addr;
	logic [SAMPLE_W-1:0] wr_data;
	logic [AddrW-1:0]    rd_addr;
	logic [SAMPLE_W-1:0] rd_data;
	rank_ctl_t           rank_ctl;
	logic [CntW-1:0]     k_lo;
	logic [CntW-1:0]     k_hi;
	logic [SAMPLE_W-1:0] lo_val;
	logic [SAMPLE_W-1:0] hi_val;
	logic                result_rdy;
	logic                result_take;
	logic [CH_W-1:0]     best_ch;
	logic [SAMPLE_W-1:0] best_med;

	logic                res_valid_q;
	logic [CH_W-1:0]     nearest_channel_q;
	logic [DEG_W-1:0]    direction_deg_q;
	logic [SAMPLE_W-1:0] nearest_median_q;

	mfns_store #(
		.DEPTH(Depth),
		.AW   (AddrW)
	) u_store (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	mfns_rank #(
		.CW(CntW)
	) u_rank (
		.clk    (clk),
		.ctl    (rank_ctl),
		.rd_data(rd_data),
		.k_lo   (k_lo),
		.k_hi   (k_hi),
		.lo_val (lo_val),
		.hi_val (hi_val)
	);

	mfns_seq #(
		.WINDOW  (WINDOW),
		.CHANNELS(CHANNELS),
		.AW      (AddrW),
		.CW      (CntW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.mode       (mode),
		.channel    (channel),
		.sample     (sample),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.rd_addr    (rd_addr),
		.rank_ctl   (rank_ctl),
		.k_lo       (k_lo),
		.k_hi       (k_hi),
		.lo_val     (lo_val),
		.hi_val     (hi_val),
		.result_rdy (result_rdy),
		.result_take(result_take),
		.best_ch    (best_ch),
		.best_med   (best_med)
	);

	// result moves into the output register once it is free
	assign result_take = result_rdy && (!res_valid_q || res_ready);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (result_take) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (result_take) begin
			nearest_channel_q <= best_ch;
			direction_deg_q   <= DEG_W'((DEG_W'(best_ch) + 1'b1) * DEG_STEP);
			nearest_median_q  <= best_med;
		end
	end

	assign res_valid       = res_valid_q;
	assign nearest_channel = nearest_channel_q;
	assign direction_deg   = direction_deg_q;
	assign nearest_median  = nearest_median_q;

endmodule

@@ tb/tb_median_filtered_nearest_sensor.sv @@
// ----------------------------------------------------------------------------
// tb_median_filtered_nearest_sensor
// Self-checking bench for the nearest sensor direction finder. Each sample
// item goes into a local copy of the per-channel sliding windows. Each query
// item turns that copy into the expected channel, direction and median, and
// results come back in order. A short table of hand-built items covers empty
// channels, ties, ignored channels and even-count medians. Random segments
// then vary the sample spread, the query rate and the idle pattern.
// ----------------------------------------------------------------------------
module tb_median_filtered_nearest_sensor
	import mfns_pkg::*;
;

	localparam int N_CH         = 12;
	localparam int WIN          = 9;
	localparam int N_SEGMENTS   = 14;
	localparam int SEG_ITEMS    = 100;
	localparam int DRAIN_CYCLES = 40;
	// allow every item to be a full-window query with the longest gaps on
	// both sides, several times over
	localparam int CYCLE_LIMIT  = 10_000_000;
	localparam int MAX_PRINTS   = 40;

	typedef struct packed {
		logic [CH_W-1:0]     ch;
		logic [DEG_W-1:0]    deg;
		logic [SAMPLE_W-1:0] med;
	} nearest_t;

	typedef struct packed {
		logic                m;
		logic [CH_W-1:0]     ch;
		logic [SAMPLE_W-1:0] smp;
		logic                typed;
		nearest_t            want;
	} stim_row_t;

	logic                clk;
	logic                arst_n;
	logic                req_valid;
	logic                req_ready;
	logic                mode;
	logic [CH_W-1:0]     channel;
	logic [SAMPLE_W-1:0] sample;
	logic                res_valid;
	logic                res_ready;
	logic [CH_W-1:0]     nearest_channel;
	logic [DEG_W-1:0]    direction_deg;
	logic [SAMPLE_W-1:0] nearest_median;

	// local copy of the channel windows
	logic [SAMPLE_W-1:0] win_mem  [N_CH][WIN];
	int unsigned         win_fill [N_CH];
	int unsigned         win_slot [N_CH];

	nearest_t pending_answers [$];
	int       err_count   = 0;
	int       cycle_count = 0;
	bit       calm        = 1'b0;

	// hand-built items; typed expectations only where obvious
	stim_row_t dir_rows [19] = '{
		{MODE_QUERY, 4'd0,  10'd0,    1'b1, 4'd0,  DEG_STEP, EMPTY_MEDIAN},
		{MODE_ADD,   4'd11, 10'd1023, 1'b0, 23'd0},
		{MODE_QUERY, 4'd0,  10'd0,    1'b1, 4'd0,  DEG_STEP, EMPTY_MEDIAN},
		{MODE_ADD,   4'd15, 10'd0,    1'b0, 23'd0},
		{MODE_ADD,   4'd12, 10'd0,    1'b0, 23'd0},
		{MODE_QUERY, 4'd0,  10'd0,    1'b1, 4'd0,  DEG_STEP, EMPTY_MEDIAN},
		{MODE_ADD,   4'd11, 10'd0,    1'b0, 23'd0},
		{MODE_QUERY, 4'd0,  10'd0,    1'b1, 4'd11, 9'd360,   10'd511},
		{MODE_ADD,   4'd5,  10'd0,    1'b0, 23'd0},
		{MODE_QUERY, 4'd0,  10'd0,    1'b1, 4'd5,  9'd180,   10'd0},
		{MODE_ADD,   4'd3,  10'd0,    1'b0, 23'd0},
		{MODE_QUERY, 4'd0,  10'd0,    1'b1, 4'd3,  9'd120,   10'd0},
		{MODE_ADD,   4'd0,  10'd1,    1'b0, 23'd0},
		{MODE_ADD,   4'd0,  10'd2,    1'b0, 23'd0},
		{MODE_QUERY, 4'd0,  10'd0,    1'b0, 23'd0},
		{MODE_ADD,   4'd3,  10'd1023, 1'b0, 23'd0},
		{MODE_QUERY, 4'd15, 10'd1023, 1'b0, 23'd0},
		{MODE_ADD,   4'd9,  10'd512,  1'b0, 23'd0},
		{MODE_QUERY, 4'd6,  10'd341,  1'b0, 23'd0}
	};

	median_filtered_nearest_sensor #(
		.WINDOW   (WIN),
		.CHANNELS (N_CH)
	) u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.mode            (mode),
		.channel         (channel),
		.sample          (sample),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.nearest_channel (nearest_channel),
		.direction_deg   (direction_deg),
		.nearest_median  (nearest_median)
	);

	// clock and reset
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n <= 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
	end

	// idle length: mostly none or short, now and then long
	function automatic int gap_len();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// median of one channel window, empty counts as full scale
	function automatic logic [SAMPLE_W-1:0] window_median(int ch);
		logic [SAMPLE_W-1:0] srt [WIN];
		logic [SAMPLE_W-1:0] v;
		logic [SAMPLE_W:0]   pair_sum;
		int n;
		int j;
		n = int'(win_fill[ch]);
		if (n == 0)
			return EMPTY_MEDIAN;
		for (int i = 0; i < n; i++) begin
			v = win_mem[ch][i];
			j = i;
			while (j > 0 && srt[j-1] > v) begin
				srt[j] = srt[j-1];
				j--;
			end
			srt[j] = v;
		end
		if (n % 2 == 1)
			return srt[n/2];
		pair_sum = {1'b0, srt[n/2-1]} + {1'b0, srt[n/2]};
		return pair_sum[SAMPLE_W:1];
	endfunction

	// lowest median wins, strict compare keeps the lowest index on ties
	function automatic nearest_t nearest_lookup();
		nearest_t best;
		logic [SAMPLE_W-1:0] m;
		int best_ch;
		best_ch  = 0;
		best.med = window_median(0);
		for (int c = 1; c < N_CH; c++) begin
			m = window_median(c);
			if (m < best.med) begin
				best.med = m;
				best_ch  = c;
			end
		end
		best.ch  = CH_W'(best_ch);
		best.deg = DEG_W'((best_ch + 1) * int'(DEG_STEP));
		return best;
	endfunction

	// ring write into a channel window; unknown channels are dropped
	function automatic void store_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] s);
		int c;
		c = int'(ch);
		if (c >= N_CH)
			return;
		win_mem[c][win_slot[c]] = s;
		win_slot[c] = (win_slot[c] + 1 >= WIN) ? 0 : win_slot[c] + 1;
		if (win_fill[c] < WIN)
			win_fill[c]++;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (err_count < MAX_PRINTS)
			$display("ERROR at %0t: %s got %0d want %0d", $time, what, got, want);
		err_count++;
	endtask

	// drive one item after an optional idle gap and update the expectations
	task automatic send_item(input logic m, input logic [CH_W-1:0] ch,
			input logic [SAMPLE_W-1:0] smp, input int gap, input logic typed,
			input nearest_t want);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		mode      <= m;
		channel   <= ch;
		sample    <= smp;
		do @(posedge clk); while (!req_ready);
		if (m == MODE_ADD)
			store_sample(ch, smp);
		else if (typed)
			pending_answers.push_back(want);
		else
			pending_answers.push_back(nearest_lookup());
	endtask

	// stimulus: table first, then random segments
	initial begin : drive_items
		stim_row_t           row;
		logic                m;
		logic [CH_W-1:0]     ch;
		logic [SAMPLE_W-1:0] smp;
		int                  style;
		int                  base;
		int                  q_pct;
		req_valid <= 1'b0;
		mode      <= MODE_ADD;
		channel   <= '0;
		sample    <= '0;
		for (int c = 0; c < N_CH; c++) begin
			win_fill[c] = 0;
			win_slot[c] = 0;
		end
		@(posedge arst_n);
		@(posedge clk);
		foreach (dir_rows[k]) begin
			row = dir_rows[k];
			send_item(row.m, row.ch, row.smp, gap_len(), row.typed, row.want);
		end
		for (int seg = 0; seg < N_SEGMENTS; seg++) begin
			calm  = ($urandom_range(0, 3) == 0);
			style = $urandom_range(0, 2);
			base  = $urandom_range(0, 1016);
			q_pct = $urandom_range(5, 25);
			for (int k = 0; k < SEG_ITEMS; k++) begin
				m = ($urandom_range(0, 99) < q_pct) ? MODE_QUERY : MODE_ADD;
				if (m == MODE_QUERY || $urandom_range(0, 9) == 0)
					ch = CH_W'($urandom_range(0, 15));
				else
					ch = CH_W'($urandom_range(0, N_CH - 1));
				// wide spread, narrow band for ties, or a few fixed values
				case (style)
					0: smp = SAMPLE_W'($urandom_range(0, 1023));
					1: smp = SAMPLE_W'(base + int'($urandom_range(0, 7)));
					default: begin
						case ($urandom_range(0, 3))
							0: smp = 10'd0;
							1: smp = 10'd1023;
							2: smp = SAMPLE_W'(base);
							default: smp = SAMPLE_W'(base + 1);
						endcase
					end
				endcase
				send_item(m, ch, smp, gap_len(), 1'b0, '0);
			end
		end
		req_valid <= 1'b0;
		calm = 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// result side back-pressure
	initial begin : accept_results
		int on_len;
		int off_len;
		res_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			on_len  = $urandom_range(1, 12);
			off_len = gap_len();
			res_ready <= 1'b1;
			repeat (on_len) @(posedge clk);
			if (off_len > 0) begin
				res_ready <= 1'b0;
				repeat (off_len) @(posedge clk);
			end
		end
	end

	// compare each accepted result with the oldest expectation
	always @(posedge clk) begin : check_results
		nearest_t want;
		if (arst_n && res_valid && res_ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected result, channel", nearest_channel, -1);
			end else begin
				want = pending_answers.pop_front();
				if (nearest_channel !== want.ch)
					report_mismatch("nearest_channel", nearest_channel, want.ch);
				if (direction_deg !== want.deg)
					report_mismatch("direction_deg", direction_deg, want.deg);
				if (nearest_median !== want.med)
					report_mismatch("nearest_median", nearest_median, want.med);
			end
		end
	end

	// hang guard
	always @(posedge clk) begin
		cycle_count = cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
